// ===== rtl/fnvht_pkg.sv =====
// Shared constants and the FNV multiply function for the FNV-1a hashed linear-probe key/value table.
// No dependencies.
package fnvht_pkg;

	// The slot count is a power of two, so the start slot is the low bits of the hash.
	localparam int CAPACITY      = 16;
	localparam int KEY_BYTES_DEF = 8;
	localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;
	localparam logic [63:0] HASH_MULT  = 64'h00000100000001B3;

	localparam logic [0:0] OP_SET = 1'b0;
	localparam logic [0:0] OP_GET = 1'b1;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// Multiplying by the FNV prime is a shift-add: (h << 40) + h * 0x1B3,
	// where 0x1B3 has bits 8, 7, 5, 4, 1 and 0 set.
	function automatic logic [63:0] fnv_mult(input logic [63:0] h);
		fnv_mult = {h[23:0], 40'h0} + {h[55:0], 8'h00} + {h[56:0], 7'h00}
			+ {h[58:0], 5'h00} + {h[59:0], 4'h0} + {h[62:0], 1'b0} + h;
	endfunction

endpackage

// ===== rtl/fnvht_ram.sv =====
// Generic RAM with one write port and one read port, with registered read.
// No dependencies.
module fnvht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/fnvht_front.sv =====
// Front part: accepts items, masks the key, hashes it one byte a cycle.
// Depends on fnvht_pkg.
module fnvht_front import fnvht_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic        op,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [31:0] value_in,
	output logic        hv,
	input  logic        hstall,
	output logic        h_op,
	output logic [63:0] h_key,
	output logic [3:0]  h_len,
	output logic [31:0] h_val,
	output logic [63:0] h_hash
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_HASH = 3'b010,
		F_DONE = 3'b100
	} fstate_t;

	fstate_t     state_q;
	logic [3:0]  cnt_q;
	logic [3:0]  len_c;
	logic [63:0] key_c;
	logic [63:0] hx;

	always_comb begin
		len_c = (key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_length;
		key_c = key_bytes;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) >= len_c) begin
				key_c[8*i +: 8] = 8'h00;
			end
		end
	end

	assign stall = (state_q != F_IDLE);
	assign hv    = (state_q == F_DONE);
	assign hx    = h_hash ^ {56'h0, h_key[{cnt_q[2:0], 3'b000} +: 8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (valid) begin
					state_q <= (len_c == 4'd0) ? F_DONE : F_HASH;
				end
				F_HASH: if (cnt_q + 4'd1 == h_len) begin
					state_q <= F_DONE;
				end
				F_DONE: if (!hstall) begin
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && valid) begin
			h_op   <= op;
			h_key  <= key_c;
			h_len  <= len_c;
			h_val  <= value_in;
			h_hash <= HASH_BASIS;
			cnt_q  <= 4'd0;
		end else if (state_q == F_HASH) begin
			h_hash <= fnv_mult(hx);
			cnt_q  <= cnt_q + 4'd1;
		end
	end
endmodule

// ===== rtl/fnvht_back.sv =====
// Back part: probes the slot store linearly, then writes on a set and reports.
// Depends on fnvht_pkg and fnvht_ram.
module fnvht_back import fnvht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hv,
	output logic        hstall,
	input  logic        h_op,
	input  logic [63:0] h_key,
	input  logic [3:0]  h_len,
	input  logic [31:0] h_val,
	input  logic [63:0] h_hash,
	output logic        valid,
	input  logic        stall,
	output logic [2:0]  status,
	output logic [31:0] value_out,
	output logic [3:0]  slot
);
	localparam int AW = $clog2(CAPACITY);
	localparam int NW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_READ = 4'b0010,
		B_CMP  = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t        state_q;
	logic           op_q;
	logic [63:0]    key_q;
	logic [3:0]     len_q;
	logic [31:0]    val_q;
	logic [AW-1:0]  idx_q;
	logic [NW-1:0]  n_q;
	logic [CAPACITY-1:0] used_q;
	logic           used_rd_q;
	logic [4:0]     entry_count_q;
	logic [67:0]    kl_rd;
	logic [31:0]    v_rd;
	logic           we_kl, we_v, hit;
	logic [AW-1:0]  start;

	// The capacity is a power of two, so the hash modulo the capacity is its low bits.
	assign start = h_hash[AW-1:0];

	assign hstall = (state_q != B_IDLE);
	assign hit    = used_rd_q && kl_rd == {len_q, key_q};
	assign we_kl  = state_q == B_CMP && !used_rd_q && op_q == OP_SET;
	assign we_v   = state_q == B_CMP && op_q == OP_SET && (!used_rd_q || hit);

	fnvht_ram #(.WIDTH(68), .DEPTH(CAPACITY)) u_kl (
		.clk(clk), .we(we_kl), .waddr(idx_q), .wdata({len_q, key_q}),
		.raddr(idx_q), .rdata(kl_rd)
	);
	fnvht_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
		.clk(clk), .we(we_v), .waddr(idx_q), .wdata(val_q),
		.raddr(idx_q), .rdata(v_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			used_q        <= '0;
			entry_count_q <= '0;
			valid         <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (hv) begin
					state_q <= B_READ;
				end
				B_READ: state_q <= B_CMP;
				B_CMP: begin
					if (!used_rd_q || hit || n_q == NW'(CAPACITY - 1)) begin
						state_q <= B_OUT;
						valid   <= 1'b1;
						if (we_kl) begin
							used_q[idx_q] <= 1'b1;
							if (entry_count_q != 5'd31) begin
								entry_count_q <= entry_count_q + 5'd1;
							end
						end
					end else begin
						state_q <= B_READ;
					end
				end
				B_OUT: if (!stall) begin
					valid   <= 1'b0;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				op_q  <= h_op;
				key_q <= h_key;
				len_q <= h_len;
				val_q <= h_val;
				idx_q <= start;
				n_q   <= '0;
			end
			B_READ: used_rd_q <= used_q[idx_q];
			B_CMP: begin
				status    <= (op_q == OP_SET) ? ST_FULL : ST_NOT_FOUND;
				value_out <= '0;
				slot      <= '0;
				if (!used_rd_q) begin
					if (op_q == OP_SET) begin
						status <= ST_INSERTED;
						slot   <= 4'(idx_q);
					end
				end else if (hit) begin
					slot <= 4'(idx_q);
					if (op_q == OP_SET) begin
						status <= ST_UPDATED;
					end else begin
						status    <= ST_FOUND;
						value_out <= v_rd;
					end
				end
				idx_q <= (idx_q == AW'(CAPACITY - 1)) ? '0 : idx_q + AW'(1);
				n_q   <= n_q + NW'(1);
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/fnv_hash_linear_probe_table.sv =====
// Hashed key/value table: FNV-1a over the key, one byte a cycle, then linear
// probing, each slot through a read state and a compare state on registered-read
// slot memories. The front hashes a new item while the back probes the previous
// one.
// Reset: asynchronous, active low; all slots read empty after reset at once.
module fnv_hash_linear_probe_table import fnvht_pkg::*; #(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] value_out,
	output logic [3:0]  slot
);
	logic        hv, hstall, h_op;
	logic [63:0] h_key, h_hash;
	logic [3:0]  h_len;
	logic [31:0] h_val;

	fnvht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.op(op), .key_bytes(key_bytes), .key_length(key_length),
		.value_in(value_in), .hv(hv), .hstall(hstall), .h_op(h_op),
		.h_key(h_key), .h_len(h_len), .h_val(h_val), .h_hash(h_hash)
	);

	fnvht_back u_back (
		.clk(clk), .arst_n(arst_n), .hv(hv), .hstall(hstall), .h_op(h_op),
		.h_key(h_key), .h_len(h_len), .h_val(h_val), .h_hash(h_hash),
		.valid(out_valid), .stall(out_stall), .status(status),
		.value_out(value_out), .slot(slot)
	);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_FULL) else $error("status out of range");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND || status == ST_FULL)
		|-> value_out == 32'd0 && slot == 4'd0) else $error("miss carries data");
	a_set_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_INSERTED || status == ST_UPDATED)
		|-> value_out == 32'd0) else $error("set carries value");
endmodule
